// File: rtl/prcf_pkg.sv
`default_nettype none

package prcf_pkg;

    localparam int SITES     = 16;
    localparam int STATES    = 3;
    localparam int MASK_BITS = 16;
    localparam int SEED_W    = 4;
    localparam int OUT_W     = 5;
    localparam int PACK_W    = 32;
    localparam int SPIN_W    = 2;
    localparam int SITE_W    = $clog2(SITES);
    localparam int CNT_W     = $clog2(SITES + 1);
    localparam int STATE_IW  = $clog2(STATES);
    localparam int PACK_SITES = (SITES < 16) ? SITES : 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_RIGHT,
        ST_LEFT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic seed;
        logic dir_left;
        logic adv;
        logic turn;
    } dp_cmd_t;

    typedef struct packed {
        logic step_ok;
    } dp_stat_t;

    function automatic logic [SPIN_W-1:0] next_state(input logic [SPIN_W-1:0] s);
        logic [SPIN_W-1:0] r;
        if (s == SPIN_W'(STATES - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SPIN_W'(1);
        end
        return r;
    endfunction

    function automatic logic [SITE_W-1:0] wrap_seed(input logic [SEED_W-1:0] s);
        logic [SITE_W-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << SEED_W); i++)
        begin
            if (s == SEED_W'(i))
            begin
                r = SITE_W'(i % SITES);
            end
        end
        return r;
    endfunction

    function automatic logic bond_open(input logic [MASK_BITS-1:0] m,
                                       input logic [SITE_W-1:0] b);
        logic r;
        r = 1'b0;
        for (int i = 0; i < MASK_BITS; i++)
        begin
            if (i < SITES && b == SITE_W'(i))
            begin
                r = m[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/potts_ring_cluster_flip_unit.sv
// the controller steps through ST_SEED, ST_RIGHT, ST_LEFT and ST_DONE after the accepting edge;
// done is high in ST_DONE, once both the right walk and the left walk have stopped
// a new update is taken only in ST_IDLE, after the done beat; busy stays high until the done beat
// the cluster walk reads and writes one site per cycle through the spin register file
// reset: asynchronous, active low; all spins to state 0, count of state 0 to SITES
// done is a single-cycle strobe; the receiver cannot stall
`default_nettype none

module potts_ring_cluster_flip_unit import prcf_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [SEED_W-1:0]    seed_site,
    input  wire logic [MASK_BITS-1:0] bond_open_mask,
    output logic                      done,
    output logic [OUT_W-1:0]          cluster_size,
    output logic [OUT_W-1:0]          count_state_zero,
    output logic [OUT_W-1:0]          count_state_one,
    output logic [OUT_W-1:0]          count_state_two,
    output logic [PACK_W-1:0]         packed_spins
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    prcf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    prcf_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .seed_site        (seed_site),
        .bond_open_mask   (bond_open_mask),
        .cluster_size     (cluster_size),
        .count_state_zero (count_state_zero),
        .count_state_one  (count_state_one),
        .count_state_two  (count_state_two),
        .packed_spins     (packed_spins)
    );

endmodule

`default_nettype wire

// File: rtl/prcf_ctrl.sv
`default_nettype none

module prcf_ctrl import prcf_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy,
    output logic          done
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                state_next = ST_RIGHT;
            end
            ST_RIGHT:
            begin
                if (!stat.step_ok)
                begin
                    state_next = ST_LEFT;
                end
            end
            ST_LEFT:
            begin
                if (!stat.step_ok)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SEED:
            begin
                cmd.seed = 1'b1;
            end
            ST_RIGHT:
            begin
                cmd.adv  = stat.step_ok;
                cmd.turn = !stat.step_ok;
            end
            ST_LEFT:
            begin
                cmd.dir_left = 1'b1;
                cmd.adv      = stat.step_ok;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/prcf_datapath.sv
`default_nettype none

module prcf_datapath import prcf_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    input  wire logic [SEED_W-1:0]    seed_site,
    input  wire logic [MASK_BITS-1:0] bond_open_mask,
    output logic [OUT_W-1:0]          cluster_size,
    output logic [OUT_W-1:0]          count_state_zero,
    output logic [OUT_W-1:0]          count_state_one,
    output logic [OUT_W-1:0]          count_state_two,
    output logic [PACK_W-1:0]         packed_spins
);

    logic [SPIN_W-1:0]    spin_reg  [SITES];
    logic [CNT_W-1:0]     count_reg [STATES];
    logic [SITE_W-1:0]    k_reg;
    logic [SITE_W-1:0]    seed_reg;
    logic [MASK_BITS-1:0] mask_reg;
    logic [SPIN_W-1:0]    old_reg;
    logic [SPIN_W-1:0]    new_reg;
    logic [CNT_W-1:0]     size_reg;

    logic [SITE_W-1:0] right_site;
    logic [SITE_W-1:0] left_site;
    logic [SITE_W-1:0] rd_addr;
    logic [SITE_W-1:0] bond_idx;
    logic [SPIN_W-1:0] rd_spin;
    logic [SPIN_W-1:0] from_state;
    logic [SPIN_W-1:0] to_state;
    logic              upd;

    assign right_site = (k_reg == SITE_W'(SITES - 1)) ? '0 : k_reg + SITE_W'(1);
    assign left_site  = (k_reg == '0) ? SITE_W'(SITES - 1) : k_reg - SITE_W'(1);

    always_comb
    begin
        if (cmd.seed)
        begin
            rd_addr = k_reg;
        end
        else if (cmd.dir_left)
        begin
            rd_addr = left_site;
        end
        else
        begin
            rd_addr = right_site;
        end
    end

    assign bond_idx     = cmd.dir_left ? left_site : k_reg;
    assign rd_spin      = spin_reg[rd_addr];
    assign stat.step_ok = bond_open(mask_reg, bond_idx) && (rd_spin == old_reg);

    assign upd        = cmd.seed || cmd.adv;
    assign from_state = cmd.seed ? rd_spin : old_reg;
    assign to_state   = cmd.seed ? next_state(rd_spin) : new_reg;

    // spins and per-state counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SITES; i++)
            begin
                spin_reg[i] <= '0;
            end
            for (int j = 0; j < STATES; j++)
            begin
                count_reg[j] <= (j == 0) ? CNT_W'(SITES) : '0;
            end
        end
        else if (upd)
        begin
            for (int i = 0; i < SITES; i++)
            begin
                if (rd_addr == SITE_W'(i))
                begin
                    spin_reg[i] <= to_state;
                end
            end
            for (int j = 0; j < STATES; j++)
            begin
                if (from_state[STATE_IW-1:0] == STATE_IW'(j))
                begin
                    count_reg[j] <= count_reg[j] - CNT_W'(1);
                end
                else if (to_state[STATE_IW-1:0] == STATE_IW'(j))
                begin
                    count_reg[j] <= count_reg[j] + CNT_W'(1);
                end
            end
        end
    end

    // walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            k_reg    <= wrap_seed(seed_site);
            seed_reg <= wrap_seed(seed_site);
            mask_reg <= bond_open_mask;
        end
        else if (cmd.seed)
        begin
            old_reg  <= rd_spin;
            new_reg  <= next_state(rd_spin);
            size_reg <= CNT_W'(1);
        end
        else if (cmd.adv)
        begin
            k_reg    <= rd_addr;
            size_reg <= size_reg + CNT_W'(1);
        end
        else if (cmd.turn)
        begin
            k_reg <= seed_reg;
        end
    end

    assign cluster_size     = OUT_W'(size_reg);
    assign count_state_zero = OUT_W'(count_reg[0]);
    assign count_state_one  = OUT_W'(count_reg[1]);

    generate
        if (STATES > 2)
        begin : g_three
            assign count_state_two = OUT_W'(count_reg[2]);
        end
        else
        begin : g_two
            assign count_state_two = '0;
        end
    endgenerate

    generate
        for (genvar g = 0; g < 16; g++)
        begin : g_pack
            if (g < PACK_SITES)
            begin : g_site
                assign packed_spins[2*g +: 2] = spin_reg[g];
            end
            else
            begin : g_none
                assign packed_spins[2*g +: 2] = 2'b00;
            end
        end
    endgenerate

endmodule

`default_nettype wire

// File: rtl/prcf_check.sv
`default_nettype none

module prcf_check import prcf_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire logic [OUT_W-1:0]  cluster_size,
    input wire logic [OUT_W-1:0]  count_state_zero,
    input wire logic [OUT_W-1:0]  count_state_one,
    input wire logic [OUT_W-1:0]  count_state_two
);

    // accepted start holds the unit busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start accepted but unit not busy");

    // result beat ends the update
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done beat not followed by idle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done beat while idle");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cluster_size != '0))
        else $error("empty cluster reported");

    // counts cover the whole ring
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (({1'b0, count_state_zero} + {1'b0, count_state_one}
                  + {1'b0, count_state_two}) == (OUT_W + 1)'(SITES)))
        else $error("state counts do not sum to ring size");

endmodule

bind potts_ring_cluster_flip_unit prcf_check u_prcf_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .cluster_size     (cluster_size),
    .count_state_zero (count_state_zero),
    .count_state_one  (count_state_one),
    .count_state_two  (count_state_two)
);

`default_nettype wire
